// ===== sv/bal_pkg.sv =====
// Shared constants, types and tree index helpers of the buddy allocator.
package bal_pkg;

  localparam int REGION_LOG2    = 16;
  localparam int MIN_BLOCK_LOG2 = 4;
  localparam int HEADER_BYTES   = 8;
  localparam int ADDR_W         = 32;
  localparam int REQ_W          = 17;
  localparam int LEVEL_COUNT    = REGION_LOG2 - MIN_BLOCK_LOG2 + 1;
  localparam int LAST_BKT       = LEVEL_COUNT - 1;
  localparam int SLOT_W         = LEVEL_COUNT - 1;
  localparam int NODE_W         = LEVEL_COUNT;
  localparam int SLOT_COUNT     = 1 << SLOT_W;
  localparam int TAIL_W         = SLOT_W + 1;
  localparam int LVL_W          = $clog2(LEVEL_COUNT);
  localparam int NEED_W         = ((REQ_W > REGION_LOG2) ? REQ_W : REGION_LOG2) + 1;
  localparam int REGION_BYTES   = 1 << REGION_LOG2;
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0081_0000;

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [NODE_W-1:0] node_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LOAD, OP_A_CHK, OP_LR, OP_LR_SET, OP_LR_A, OP_LR_B,
    OP_POP, OP_GOT, OP_DESC, OP_DESC2, OP_F_CHK, OP_F_LVL, OP_F_LOOP, OP_F_FLIP,
    OP_F_UP, OP_F_END, OP_FL_RD, OP_FL_WR, OP_PU0, OP_PU1, OP_PU2, OP_RM0,
    OP_RM1, OP_DONE
  } op_e;

  // Controller states
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_A_CHK, ST_LR, ST_LR_SET, ST_LR_A, ST_LR_B, ST_POP,
    ST_GOT, ST_DESC, ST_DESC2, ST_F_CHK, ST_F_LVL, ST_F_LOOP, ST_F_FLIP,
    ST_F_UP, ST_F_END, ST_FL_RD, ST_FL_WR, ST_PU0, ST_PU1, ST_PU2, ST_RM0,
    ST_RM1, ST_DONE
  } st_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_big;
    logic started;
    logic lr_go;
    logic split_rd;
    logic tail_valid;
    logic retry;
    logic b_zero;
    logic b_eq_root;
    logic b_lt_orig;
    logic i_zero;
    logic root_one;
    logic free_null;
    logic free_bad;
    logic out_free;
  } sts_t;

  // Tree node of a slot at bucket b
  function automatic node_t node_of(slot_t s, lvl_t b);
    lvl_t  sh;
    node_t one;
    sh  = lvl_t'(LAST_BKT) - b;
    one = node_t'(1);
    return node_t'(s >> sh) + (one << b) - one;
  endfunction

  // First slot covered by a node at bucket b
  function automatic slot_t slot_of(node_t n, lvl_t b);
    lvl_t  sh;
    node_t one;
    node_t d;
    sh  = lvl_t'(LAST_BKT) - b;
    one = node_t'(1);
    d   = n - ((one << b) - one);
    return slot_t'(d << sh);
  endfunction

  // Split bit index of a node's parent
  function automatic slot_t parent_bit(node_t n);
    return slot_t'((n - node_t'(1)) >> 1);
  endfunction

  // Bucket of the smallest block that holds need bytes
  function automatic lvl_t bucket_for(logic [NEED_W-1:0] need);
    lvl_t r;
    r = '0;
    for (int k = LAST_BKT; k >= 0; k--) begin
      if (longint'(need) <= (longint'(1) << (MIN_BLOCK_LOG2 + k))) r = lvl_t'(LAST_BKT - k);
    end
    return r;
  endfunction

endpackage

// ===== sv/bal_ctrl.sv =====
// Sequencer of the buddy allocator: walks alloc/free flows and list/bit subroutines.
module bal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          kind_i,
  input  bal_pkg::sts_t sts_i,
  output bal_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);
  import bal_pkg::*;

  st_e st_q, st_d;
  st_e ret_q, ret_d;

  // State and return registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLEAR;
      ret_q <= ST_IDLE;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    st_d       = st_q;
    ret_d      = ret_q;
    cmd_o.op   = OP_NOP;
    in_stall_o = 1'b1;
    case (st_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) st_d = ST_IDLE;
        else cmd_o.op = OP_CLR;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          st_d     = kind_i ? ST_F_CHK : ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        cmd_o.op = OP_A_CHK;
        if (sts_i.need_big) st_d = ST_DONE;
        else if (!sts_i.started) begin
          st_d  = ST_PU0;
          ret_d = ST_LR;
        end else st_d = ST_LR;
      end
      ST_LR: begin
        cmd_o.op = OP_LR;
        st_d     = sts_i.lr_go ? ST_LR_SET : ST_POP;
      end
      ST_LR_SET: begin
        cmd_o.op = OP_LR_SET;
        if (sts_i.split_rd) begin
          st_d  = ST_PU0;
          ret_d = ST_LR_B;
        end else begin
          st_d  = ST_RM0;
          ret_d = ST_LR_A;
        end
      end
      ST_LR_A: begin
        cmd_o.op = OP_LR_A;
        st_d     = ST_PU0;
        ret_d    = ST_LR;
      end
      ST_LR_B: begin
        cmd_o.op = OP_LR_B;
        if (sts_i.root_one) st_d = ST_LR;
        else begin
          st_d  = ST_FL_RD;
          ret_d = ST_LR;
        end
      end
      ST_POP: begin
        cmd_o.op = OP_POP;
        if (sts_i.tail_valid) begin
          st_d  = ST_RM0;
          ret_d = ST_GOT;
        end else if (sts_i.retry || sts_i.b_zero) st_d = ST_DONE;
        else st_d = ST_LR;
      end
      ST_GOT: begin
        cmd_o.op = OP_GOT;
        if (sts_i.b_zero) st_d = ST_DESC;
        else begin
          st_d  = ST_FL_RD;
          ret_d = ST_DESC;
        end
      end
      ST_DESC: begin
        cmd_o.op = OP_DESC;
        if (sts_i.b_lt_orig) begin
          st_d  = ST_FL_RD;
          ret_d = ST_DESC2;
        end else st_d = ST_DONE;
      end
      ST_DESC2: begin
        cmd_o.op = OP_DESC2;
        st_d     = ST_PU0;
        ret_d    = ST_DESC;
      end
      ST_F_CHK: begin
        cmd_o.op = OP_F_CHK;
        st_d     = (sts_i.free_null || sts_i.free_bad) ? ST_DONE : ST_F_LVL;
      end
      ST_F_LVL: begin
        cmd_o.op = OP_F_LVL;
        st_d     = ST_F_LOOP;
      end
      ST_F_LOOP: begin
        cmd_o.op = OP_F_LOOP;
        st_d     = sts_i.i_zero ? ST_F_END : ST_F_FLIP;
      end
      ST_F_FLIP: begin
        cmd_o.op = OP_F_FLIP;
        if (!sts_i.split_rd || sts_i.b_eq_root) st_d = ST_F_END;
        else begin
          st_d  = ST_RM0;
          ret_d = ST_F_UP;
        end
      end
      ST_F_UP: begin
        cmd_o.op = OP_F_UP;
        st_d     = ST_F_LOOP;
      end
      ST_F_END: begin
        cmd_o.op = OP_F_END;
        st_d     = ST_PU0;
        ret_d    = ST_DONE;
      end
      // split bit toggle
      ST_FL_RD: begin
        cmd_o.op = OP_FL_RD;
        st_d     = ST_FL_WR;
      end
      ST_FL_WR: begin
        cmd_o.op = OP_FL_WR;
        st_d     = ret_q;
      end
      // free list push
      ST_PU0: begin
        cmd_o.op = OP_PU0;
        st_d     = sts_i.tail_valid ? ST_PU1 : ret_q;
      end
      ST_PU1: begin
        cmd_o.op = OP_PU1;
        st_d     = ST_PU2;
      end
      ST_PU2: begin
        cmd_o.op = OP_PU2;
        st_d     = ret_q;
      end
      // free list removal
      ST_RM0: begin
        cmd_o.op = OP_RM0;
        st_d     = ST_RM1;
      end
      ST_RM1: begin
        cmd_o.op = OP_RM1;
        st_d     = ret_q;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_DONE;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/bal_dpath.sv =====
// Datapath of the buddy allocator: tree memories, list tails, working and result registers.
module bal_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bal_pkg::cmd_t                cmd_i,
  output bal_pkg::sts_t                sts_o,
  input  logic                         cfg_we_i,
  input  logic [bal_pkg::ADDR_W-1:0]   cfg_data_i,
  input  logic [bal_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [bal_pkg::ADDR_W-1:0]   block_address_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [bal_pkg::ADDR_W-1:0]   result_address_o,
  output logic                         success_o
);
  import bal_pkg::*;

  // Control state
  logic [ADDR_W-1:0] base_q;
  logic              started_q;
  lvl_t              root_q;
  logic [TAIL_W-1:0] tail_q [LEVEL_COUNT];
  logic [SLOT_W:0]   clr_q;
  logic              out_valid_q;

  // Working registers
  lvl_t              b_q, orig_q, lrt_q, lb_q;
  logic              retry_q;
  node_t             i_q;
  slot_t             s_q, le_q, fa_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] res_addr_q, out_addr_q;
  logic              res_ok_q, out_ok_q;

  // Memories and their read registers
  logic  split_mem [SLOT_COUNT];
  slot_t prev_mem  [SLOT_COUNT];
  slot_t next_mem  [SLOT_COUNT];
  lvl_t  lvl_mem   [SLOT_COUNT];
  logic  split_rd_q;
  slot_t prev_rd_q, next_rd_q;
  lvl_t  lvl_rd_q;

  // Port controls
  logic  split_we, split_wd, split_re;
  slot_t split_wa, split_ra;
  logic  prev_we, prev_re, next_we, next_re;
  slot_t prev_wa, prev_wd, prev_ra, next_wa, next_wd, next_ra;
  logic  lvl_we, lvl_re;
  slot_t lvl_wa, lvl_ra;
  logic  tail_we;
  lvl_t  tail_wa;
  logic [TAIL_W-1:0] tail_wd;

  // Derived values
  logic [NEED_W-1:0] need;
  logic              need_big;
  lvl_t              bkt;
  logic [ADDR_W-1:0] off;
  slot_t             off_slot;
  logic              free_bad;
  node_t             root_node, new_root, i_next, i_buddy, i_par;
  logic [TAIL_W-1:0] tail_lb;
  slot_t             t_e;
  logic              t_v, le_is_tail;
  lvl_t              lvl_clamp, root_dec;

  assign need       = NEED_W'(req_q) + NEED_W'(HEADER_BYTES);
  assign need_big   = need > NEED_W'(REGION_BYTES);
  assign bkt        = bucket_for(need);
  assign off        = addr_q - ADDR_W'(HEADER_BYTES) - base_q;
  assign off_slot   = off[MIN_BLOCK_LOG2 +: SLOT_W];
  assign free_bad   = !started_q || (|off[ADDR_W-1:REGION_LOG2]) ||
                      (|off[MIN_BLOCK_LOG2-1:0]);
  assign root_node  = (node_t'(1) << root_q) - node_t'(1);
  assign new_root   = (root_node - node_t'(1)) >> 1;
  assign i_next     = {i_q[NODE_W-2:0], 1'b1};
  assign i_buddy    = ((i_q - node_t'(1)) ^ node_t'(1)) + node_t'(1);
  assign i_par      = (i_q - node_t'(1)) >> 1;
  assign tail_lb    = tail_q[lb_q];
  assign t_e        = tail_lb[SLOT_W-1:0];
  assign t_v        = tail_lb[SLOT_W];
  assign le_is_tail = (tail_lb == {1'b1, le_q});
  assign lvl_clamp  = (lvl_rd_q > lvl_t'(LAST_BKT)) ? lvl_t'(LAST_BKT) : lvl_rd_q;
  assign root_dec   = root_q - lvl_t'(1);

  // Memory and tail port selection
  always_comb begin
    split_we = 1'b0; split_wa = '0; split_wd = 1'b0; split_re = 1'b0; split_ra = '0;
    prev_we  = 1'b0; prev_wa  = '0; prev_wd  = '0;   prev_re  = 1'b0; prev_ra  = '0;
    next_we  = 1'b0; next_wa  = '0; next_wd  = '0;   next_re  = 1'b0; next_ra  = '0;
    lvl_we   = 1'b0; lvl_wa   = '0; lvl_re   = 1'b0; lvl_ra   = '0;
    tail_we  = 1'b0; tail_wa  = lb_q; tail_wd = '0;
    case (cmd_i.op)
      OP_CLR: begin
        split_we = 1'b1;
        split_wa = clr_q[SLOT_W-1:0];
      end
      OP_A_CHK: begin
        if (!need_big && !started_q) begin
          tail_we = 1'b1;
          tail_wa = lvl_t'(LAST_BKT);
        end
      end
      OP_LR: begin
        split_re = 1'b1;
        split_ra = parent_bit(root_node);
      end
      OP_LR_A, OP_LR_B: begin
        tail_we = 1'b1;
        tail_wa = root_dec;
      end
      OP_DESC: begin
        if (!(b_q < orig_q)) begin
          lvl_we = 1'b1;
          lvl_wa = s_q;
        end
      end
      OP_F_CHK: begin
        lvl_re = 1'b1;
        lvl_ra = off_slot;
      end
      OP_F_LOOP: begin
        split_re = 1'b1;
        split_ra = parent_bit(i_q);
      end
      OP_FL_RD: begin
        split_re = 1'b1;
        split_ra = fa_q;
      end
      OP_FL_WR, OP_F_FLIP: begin
        split_we = 1'b1;
        split_wa = fa_q;
        split_wd = ~split_rd_q;
      end
      OP_PU0: begin
        if (!t_v) begin
          prev_we = 1'b1; prev_wa = le_q; prev_wd = le_q;
          next_we = 1'b1; next_wa = le_q; next_wd = le_q;
          tail_we = 1'b1; tail_wd = {1'b1, le_q};
        end else begin
          next_re = 1'b1; next_ra = t_e;
        end
      end
      OP_PU1: begin
        prev_we = 1'b1; prev_wa = le_q; prev_wd = t_e;
        next_we = 1'b1; next_wa = le_q; next_wd = next_rd_q;
      end
      OP_PU2: begin
        next_we = 1'b1; next_wa = t_e;       next_wd = le_q;
        prev_we = 1'b1; prev_wa = next_rd_q; prev_wd = le_q;
        tail_we = 1'b1; tail_wd = {1'b1, le_q};
      end
      OP_RM0: begin
        prev_re = 1'b1; prev_ra = le_q;
        next_re = 1'b1; next_ra = le_q;
      end
      OP_RM1: begin
        if (next_rd_q == le_q) begin
          tail_we = le_is_tail;
        end else begin
          next_we = 1'b1; next_wa = prev_rd_q; next_wd = next_rd_q;
          prev_we = 1'b1; prev_wa = next_rd_q; prev_wd = prev_rd_q;
          tail_we = le_is_tail;
          tail_wd = {1'b1, prev_rd_q};
        end
      end
      default: ;
    endcase
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (split_we) split_mem[split_wa] <= split_wd;
    if (split_re) split_rd_q <= split_mem[split_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) lvl_mem[lvl_wa] <= orig_q;
    if (lvl_re) lvl_rd_q <= lvl_mem[lvl_ra];
  end

  // Control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BASE_RESET;
      started_q   <= 1'b0;
      root_q      <= lvl_t'(LAST_BKT);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < LEVEL_COUNT; k++) tail_q[k] <= '0;
    end else begin
      if (cfg_we_i) base_q <= cfg_data_i;
      if (tail_we) tail_q[tail_wa] <= tail_wd;
      if (cmd_i.op == OP_CLR) clr_q <= clr_q + 1'b1;
      if (cmd_i.op == OP_A_CHK && !need_big && !started_q) begin
        started_q <= 1'b1;
        root_q    <= lvl_t'(LAST_BKT);
      end
      if (cmd_i.op == OP_LR_A || cmd_i.op == OP_LR_B) root_q <= root_dec;
      if (cmd_i.op == OP_DONE) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q  <= request_bytes_i;
        addr_q <= block_address_i;
      end
      OP_A_CHK: begin
        orig_q     <= bkt;
        b_q        <= bkt;
        lrt_q      <= bkt;
        retry_q    <= 1'b0;
        res_addr_q <= '0;
        res_ok_q   <= 1'b0;
        lb_q       <= lvl_t'(LAST_BKT);
        le_q       <= '0;
      end
      OP_LR: begin
        if (!(lrt_q < root_q)) lb_q <= b_q;
      end
      OP_LR_SET: begin
        lb_q <= root_q;
        le_q <= split_rd_q ? slot_of(root_node + node_t'(1), root_q) : '0;
      end
      OP_LR_A: begin
        lb_q <= root_dec;
        le_q <= '0;
      end
      OP_LR_B: fa_q <= parent_bit(new_root);
      OP_POP: begin
        if (t_v) begin
          s_q  <= t_e;
          le_q <= t_e;
        end else if (!retry_q && b_q != '0) begin
          lrt_q <= b_q - lvl_t'(1);
          if (b_q != root_q) b_q <= b_q - lvl_t'(1);
          else retry_q <= 1'b1;
        end
      end
      OP_GOT: begin
        i_q  <= node_of(s_q, b_q);
        fa_q <= parent_bit(node_of(s_q, b_q));
      end
      OP_DESC: begin
        if (b_q < orig_q) begin
          i_q  <= i_next;
          b_q  <= b_q + lvl_t'(1);
          fa_q <= parent_bit(i_next);
        end else begin
          res_addr_q <= base_q + (ADDR_W'(s_q) << MIN_BLOCK_LOG2) + ADDR_W'(HEADER_BYTES);
          res_ok_q   <= 1'b1;
        end
      end
      OP_DESC2: begin
        lb_q <= b_q;
        le_q <= slot_of(i_q + node_t'(1), b_q);
      end
      OP_F_CHK: begin
        res_addr_q <= '0;
        res_ok_q   <= (addr_q == '0);
        s_q        <= off_slot;
      end
      OP_F_LVL: begin
        b_q <= lvl_clamp;
        i_q <= node_of(s_q, lvl_clamp);
      end
      OP_F_LOOP: fa_q <= parent_bit(i_q);
      OP_F_FLIP: begin
        lb_q <= b_q;
        le_q <= slot_of(i_buddy, b_q);
      end
      OP_F_UP: begin
        i_q <= i_par;
        b_q <= b_q - lvl_t'(1);
      end
      OP_F_END: begin
        lb_q     <= b_q;
        le_q     <= slot_of(i_q, b_q);
        res_ok_q <= 1'b1;
      end
      OP_DONE: begin
        out_addr_q <= res_addr_q;
        out_ok_q   <= res_ok_q;
      end
      default: ;
    endcase
  end

  // Status to the controller
  always_comb begin
    sts_o.clr_done   = clr_q[SLOT_W];
    sts_o.need_big   = need_big;
    sts_o.started    = started_q;
    sts_o.lr_go      = lrt_q < root_q;
    sts_o.split_rd   = split_rd_q;
    sts_o.tail_valid = t_v;
    sts_o.retry      = retry_q;
    sts_o.b_zero     = (b_q == '0);
    sts_o.b_eq_root  = (b_q == root_q);
    sts_o.b_lt_orig  = b_q < orig_q;
    sts_o.i_zero     = (i_q == '0);
    sts_o.root_one   = (root_q == lvl_t'(1));
    sts_o.free_null  = (addr_q == '0);
    sts_o.free_bad   = free_bad;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign success_o        = out_ok_q;

endmodule

// ===== sv/buddy_allocator_unit.sv =====
// Top level of the buddy allocator: controller, datapath and port glue.
//
// Input channel (in_valid_i / in_stall_o): kind_i 0 allocates request_bytes_i
// bytes, kind_i 1 frees block_address_i. Output channel (out_valid_o /
// out_stall_i): one transfer per item with result_address_o and success_o.
// Config channel (cfg_valid_i / cfg_ready_o): writes region_base, always ready.
// One item is in work at a time. Rejected or null items skip the tree walk;
// each tree level walked adds a split or merge step plus its free-list update.
// An alloc may have to lower the root and split down across all 13 levels.
// Each tree step costs a read-modify-write on the one-read/one-write ports
// of the split-bit and link memories. After reset the split-bit memory is
// cleared one entry per cycle; in_stall_o stays high until done.
// The result sits in an output register: a stalled receiver holds it there
// while the next item is already taken and worked on; that item finishes
// only once the register is free.
module buddy_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bal_pkg::ADDR_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [bal_pkg::REQ_W-1:0]  request_bytes_i,
  input  logic [bal_pkg::ADDR_W-1:0] block_address_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bal_pkg::ADDR_W-1:0] result_address_o,
  output logic                       success_o
);
  import bal_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && !in_stall_o;

  bal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  bal_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .request_bytes_i  (request_bytes_i),
    .block_address_i  (block_address_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .result_address_o (result_address_o),
    .success_o        (success_o)
  );

  // No item is taken before the split-bit clear finishes
  a_load_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_LOAD) |-> sts.clr_done)
    else $error("item accepted during split-bit clear");

  // A failed item always reports a zero address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !success_o) |-> (result_address_o == '0))
    else $error("failed result with nonzero address");

  // The output register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_DONE) |-> sts.out_free)
    else $error("result loaded over a stalled result");

  // After an input transfer the block is busy
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled while an item is in work");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for buddy_allocator_unit: predicts alloc/free results and checks each transfer.
module tb_top;
  import bal_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int unsigned SMASK  = SLOT_COUNT - 1;
  localparam int unsigned TVALID = SLOT_COUNT;

  typedef enum logic {KIND_ALLOC = 1'b0, KIND_FREE = 1'b1} kind_e;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              ok;
  } outcome_t;

  // Buddy tree predictor plus queue of pending outcomes
  class alloc_scoreboard;
    logic [ADDR_W-1:0] base;
    bit          started;
    int unsigned root_lvl;
    bit          split[SLOT_COUNT];
    int unsigned tail[LEVEL_COUNT];
    int unsigned prv[SLOT_COUNT];
    int unsigned nxt[SLOT_COUNT];
    int unsigned lvl[SLOT_COUNT];
    bit          written[SLOT_COUNT];
    int unsigned written_q[$];
    int unsigned live_q[$];
    outcome_t    pending_q[$];
    int          errors;

    function void clear_state();
      base     = BASE_RESET;
      started  = 0;
      root_lvl = LAST_BKT;
      errors   = 0;
      foreach (split[k]) begin
        split[k] = 0; prv[k] = 0; nxt[k] = 0; lvl[k] = 0; written[k] = 0;
      end
      foreach (tail[k]) tail[k] = 0;
    endfunction

    function int unsigned pbit(int unsigned n);
      return ((n - 1) >> 1) & SMASK;
    endfunction

    function int unsigned node_at(int unsigned s, int unsigned b);
      return ((s & SMASK) >> (LAST_BKT - b)) + (1 << b) - 1;
    endfunction

    function int unsigned slot_at(int unsigned n, int unsigned b);
      return ((n - ((1 << b) - 1)) << (LAST_BKT - b)) & SMASK;
    endfunction

    function void push(int unsigned b, int unsigned e);
      int unsigned t, h;
      e = e & SMASK;
      if ((tail[b] & TVALID) == 0) begin
        prv[e] = e;
        nxt[e] = e;
      end else begin
        t = tail[b] & SMASK;
        h = nxt[t] & SMASK;
        prv[e] = t;
        nxt[e] = h;
        nxt[t] = e;
        prv[h] = e;
      end
      tail[b] = e | TVALID;
    endfunction

    function void unlink(int unsigned b, int unsigned e);
      int unsigned p, n;
      e = e & SMASK;
      p = prv[e] & SMASK;
      n = nxt[e] & SMASK;
      if (n == e) begin
        if (tail[b] == (e | TVALID)) tail[b] = 0;
        return;
      end
      nxt[p] = n;
      prv[n] = p;
      if (tail[b] == (e | TVALID)) tail[b] = p | TVALID;
    endfunction

    function bit pop(int unsigned b, output int unsigned e);
      e = 0;
      if ((tail[b] & TVALID) == 0) return 0;
      e = tail[b] & SMASK;
      unlink(b, e);
      return 1;
    endfunction

    // Grow the tree upward until the root covers bucket b
    function void grow_root(int unsigned b);
      int unsigned root;
      while (b < root_lvl) begin
        root = (1 << root_lvl) - 1;
        if (!split[pbit(root)]) begin
          unlink(root_lvl, 0);
          root_lvl--;
          tail[root_lvl] = 0;
          push(root_lvl, 0);
        end else begin
          push(root_lvl, slot_at(root + 1, root_lvl));
          root_lvl--;
          tail[root_lvl] = 0;
          root = (root - 1) >> 1;
          if (root != 0) split[pbit(root)] ^= 1'b1;
        end
      end
    endfunction

    function bit alloc(int unsigned req, output logic [ADDR_W-1:0] addr);
      int unsigned need, target, ub, s, i, size;
      int b;
      addr = '0;
      need = req + HEADER_BYTES;
      if (need > REGION_BYTES) return 0;
      if (!started) begin
        started  = 1;
        root_lvl = LAST_BKT;
        tail[LAST_BKT] = 0;
        push(LAST_BKT, 0);
      end
      target = LAST_BKT;
      size   = 1 << MIN_BLOCK_LOG2;
      while (size < need && target > 0) begin
        target--;
        size = size << 1;
      end
      b = target;
      while (b >= 0) begin
        ub = b;
        grow_root(ub);
        if (!pop(ub, s)) begin
          if (ub != root_lvl || ub == 0) begin
            b--;
            continue;
          end
          grow_root(ub - 1);
          if (!pop(ub, s)) return 0;
        end
        i = node_at(s, ub);
        if (i != 0) split[pbit(i)] ^= 1'b1;
        // split down to the requested bucket, buddies go on the free lists
        while (ub < target) begin
          i = i * 2 + 1;
          ub++;
          split[pbit(i)] ^= 1'b1;
          push(ub, slot_at(i + 1, ub));
        end
        s = s & SMASK;
        lvl[s] = target;
        if (!written[s]) begin
          written[s] = 1;
          written_q.push_back(s);
        end
        live_q.push_back(s);
        addr = base + (s << MIN_BLOCK_LOG2) + HEADER_BYTES;
        return 1;
      end
      return 0;
    endfunction

    function bit release_block(logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] off;
      int unsigned s, b, i;
      if (addr == 0) return 1;
      if (!started) return 0;
      off = addr - HEADER_BYTES - base;
      if (off >= REGION_BYTES || off[MIN_BLOCK_LOG2-1:0] != 0) return 0;
      s = (off >> MIN_BLOCK_LOG2) & SMASK;
      b = lvl[s];
      if (b > LAST_BKT) b = LAST_BKT;
      i = node_at(s, b);
      // merge with free buddies on the way up
      while (i != 0) begin
        split[pbit(i)] ^= 1'b1;
        if (split[pbit(i)] || b == root_lvl) break;
        unlink(b, slot_at(((i - 1) ^ 1) + 1, b));
        i = (i - 1) >> 1;
        b--;
      end
      push(b, slot_at(i, b));
      return 1;
    endfunction

    // Free of an aligned in-region address that never held a block is off limits
    function bit addr_allowed(logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] off;
      off = addr - HEADER_BYTES - base;
      if (addr == 0 || off >= REGION_BYTES || off[MIN_BLOCK_LOG2-1:0] != 0) return 1;
      return written[off >> MIN_BLOCK_LOG2];
    endfunction

    function logic [ADDR_W-1:0] addr_of(int unsigned s);
      return base + (s << MIN_BLOCK_LOG2) + HEADER_BYTES;
    endfunction

    function void note_input(kind_e k, int unsigned req, logic [ADDR_W-1:0] addr);
      outcome_t o;
      if (k == KIND_ALLOC) begin
        o.ok = alloc(req, o.addr);
      end else begin
        o.ok   = release_block(addr);
        o.addr = '0;
      end
      if (!o.ok) o.addr = '0;
      pending_q.push_back(o);
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic ok);
      outcome_t o;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: result_address=%h success=%b", addr, ok);
        errors++;
        return;
      end
      o = pending_q.pop_front();
      if (addr !== o.addr) begin
        $error("result_address: expected %h, actual %h", o.addr, addr);
        errors++;
      end
      if (ok !== o.ok) begin
        $error("success: expected %b, actual %b", o.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ADDR_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              kind_i;
  logic [REQ_W-1:0]  request_bytes_i;
  logic [ADDR_W-1:0] block_address_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ADDR_W-1:0] result_address_o;
  logic              success_o;

  alloc_scoreboard sb;
  bit              no_idle;
  int              quiet_cycles;

  buddy_allocator_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .request_bytes_i (request_bytes_i),
    .block_address_i (block_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_address_o(result_address_o),
    .success_o       (success_o)
  );

  // 12-unit clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: check each transfer, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(result_address_o, success_o);
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 13);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called just after a rising edge
  task automatic write_base(logic [ADDR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.base = value;
  endtask

  task automatic send_item(kind_e k, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr);
    in_valid_i      <= 1'b1;
    kind_i          <= k;
    request_bytes_i <= req;
    block_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(k, req, addr);
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One random item, mostly well-formed alloc/free traffic
  task automatic random_item();
    int unsigned pick, idx, sel;
    logic [ADDR_W-1:0] addr;
    logic [REQ_W-1:0]  req;
    pick = $urandom_range(99);
    req  = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
    addr = $urandom;
    if (sb.live_q.size() > 150) pick = 0;
    if (sb.live_q.size() != 0 && pick < 42) begin
      idx = $urandom_range(0, sb.live_q.size() - 1);
      addr = sb.addr_of(sb.live_q[idx]);
      sb.live_q.delete(idx);
      send_item(KIND_FREE, req, addr);
    end else if (pick < 43 && sb.written_q.size() != 0) begin
      // double free of a slot that held a block
      idx = $urandom_range(0, sb.written_q.size() - 1);
      send_item(KIND_FREE, req, sb.addr_of(sb.written_q[idx]));
    end else if (pick < 49) begin
      if (!sb.addr_allowed(addr)) addr[0] = ~addr[0];
      send_item(KIND_FREE, req, addr);
    end else if (pick < 51) begin
      send_item(KIND_FREE, req, '0);
    end else begin
      sel = $urandom_range(99);
      if (sel < 70)      req = REQ_W'($urandom_range(0, 120));
      else if (sel < 90) req = REQ_W'($urandom_range(121, 2000));
      else if (sel < 98) req = REQ_W'($urandom_range(2001, 20000));
      send_item(KIND_ALLOC, req, addr);
    end
  endtask

  task automatic directed_items();
    logic [ADDR_W-1:0] whole;
    send_item(KIND_FREE, '0, '0);                        // null before any alloc
    send_item(KIND_FREE, '1, 32'hFFFF_FFFF);             // free before started
    send_item(KIND_ALLOC, 17'd65529, '0);                // just too large
    send_item(KIND_ALLOC, '1, '1);                       // largest request
    send_item(KIND_ALLOC, 17'd65528, '0);                // whole region
    whole = sb.addr_of(0);
    send_item(KIND_ALLOC, '0, '0);                       // region full
    send_item(KIND_FREE, '0, whole);
    void'(sb.live_q.pop_back());
    send_item(KIND_ALLOC, '0, '0);                       // smallest block
    send_item(KIND_ALLOC, 17'd8, '0);                    // exactly one small block
    send_item(KIND_ALLOC, 17'd9, '0);                    // one byte over
    send_item(KIND_ALLOC, 17'd32760, '0);                // half region
    send_item(KIND_FREE, '0, whole + 1);                 // misaligned
    send_item(KIND_FREE, '0, whole - 16);                // below the region
    send_item(KIND_FREE, '0, whole + REGION_BYTES);      // past the region
    send_item(KIND_FREE, '0, '0);                        // null after start
    while (sb.live_q.size() != 0) send_item(KIND_FREE, '0, sb.addr_of(sb.live_q.pop_front()));
  endtask

  initial begin
    logic [ADDR_W-1:0] bases[4];
    sb = new();
    sb.clear_state();
    no_idle         = 1'b0;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = 1'b0;
    request_bytes_i = '0;
    block_address_i = '0;
    out_stall_i     = 1'b0;
    bases[0] = BASE_RESET;
    bases[1] = 32'hFFFF_FFF0;                            // addresses wrap
    bases[2] = '0;
    bases[3] = $urandom & ~32'hF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      write_base(bases[ph]);
      if (ph == 0) directed_items();
      no_idle = (ph == 2);
      for (int n = 0; n < 340; n++) begin
        random_item();
        if (n == 170) drain();                           // sender waits for all results
      end
      no_idle = 1'b0;
      drain();
    end
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
